### src/assert_macros.svh
// Assertion macros for the cache controller back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while reset is applied.
`define SWLC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define SWLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### src/swlc_pkg.sv
// Shared types and constants of the cache tag controller.
package swlc_pkg;
	localparam int ADDR_W = 32;
	localparam int IDX_VAL_W = 15;
	localparam int DEF_NUM_WAYS = 4;
	localparam int DEF_NUM_SETS = 256;
	localparam int DEF_STAMP_BITS = 32;

	localparam logic [3:0] RST_INDEX_BITS = 4'd6;
	localparam logic [3:0] RST_OFFSET_BITS = 4'd4;
	localparam logic [2:0] RST_WAYS_IN_USE = 3'd4;

	localparam logic [1:0] REG_INDEX_BITS = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

	typedef struct packed {
		logic [3:0] index_bits;
		logic [3:0] offset_bits;
		logic [2:0] ways_in_use;
	} cfg_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_LRU,
		S_WRITE
	} back_state_t;
endpackage

### src/set_assoc_writeback_cache_lru_core.sv
// Top level of the set-associative write-back cache tag controller with LRU.
// Usage:
// Accesses (op, address) enter through push/full; a transfer happens when push
// is high and full is low. Results (hit, way_used, write_back,
// evicted_block_address) leave through empty/pop in access order; the oldest
// result is on the ports while empty is low and transfers when pop is high.
// Configuration (index_bits, offset_bits, ways_in_use) is written over the APB
// port at byte addresses 0, 4, 8; the user must write it only while the block
// is idle, as the block itself does not enforce this. The front computes the
// set index, with an extra division step when the set count is not a power of
// two; the back reads the set, compares all ways at once and, on a miss with
// all ways in use valid and more than one in use, scans timestamps one way per
// cycle. The back goes through S_IDLE (pop, read the set), S_LOOK (compare),
// S_LRU (scan) and S_WRITE (update, push the result once the output queue has
// room), one access at a time. After reset the valid/dirty memory is cleared
// one set per cycle over all NUM_SETS sets, during which full stays high.
// If the receiver stalls, results wait in a two-entry output queue, then the
// back waits, the request queue fills and full rises; nothing is dropped.
module set_assoc_writeback_cache_lru_core #(
	parameter int NUM_WAYS = swlc_pkg::DEF_NUM_WAYS,
	parameter int NUM_SETS = swlc_pkg::DEF_NUM_SETS,
	parameter int STAMP_BITS = swlc_pkg::DEF_STAMP_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [swlc_pkg::ADDR_W-1:0] address,
	output logic        empty,
	input  logic        pop,
	output logic        hit,
	output logic [1:0]  way_used,
	output logic        write_back,
	output logic [swlc_pkg::ADDR_W-1:0] evicted_block_address
);
	import swlc_pkg::*;

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int REQ_W = SET_W + ADDR_W + 1;
	localparam int RES_W = ADDR_W + 4;

	cfg_t cfg_q;
	logic clearing, req_push, req_full, req_pop, req_empty;
	logic out_push, out_full;
	logic [REQ_W-1:0] req_wdata, req_rdata;
	logic [RES_W-1:0] out_wdata, out_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.index_bits <= RST_INDEX_BITS;
			cfg_q.offset_bits <= RST_OFFSET_BITS;
			cfg_q.ways_in_use <= RST_WAYS_IN_USE;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_INDEX_BITS: cfg_q.index_bits <= pwdata[3:0];
				REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[3:0];
				REG_WAYS_IN_USE: cfg_q.ways_in_use <= pwdata[2:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_INDEX_BITS: prdata = 32'(cfg_q.index_bits);
			REG_OFFSET_BITS: prdata = 32'(cfg_q.offset_bits);
			REG_WAYS_IN_USE: prdata = 32'(cfg_q.ways_in_use);
			default: prdata = '0;
		endcase
	end

	swlc_front #(.NUM_SETS(NUM_SETS), .SET_W(SET_W)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .clearing(clearing),
		.push(push), .full(full), .op(op), .address(address),
		.req_push(req_push), .req_data(req_wdata), .req_full(req_full)
	);

	swlc_fifo #(.WIDTH(REQ_W), .DEPTH(2)) u_req_q (
		.clk(clk), .arst_n(arst_n), .push(req_push), .wdata(req_wdata), .full(req_full),
		.pop(req_pop), .rdata(req_rdata), .empty(req_empty)
	);

	swlc_back #(
		.NUM_WAYS(NUM_WAYS), .NUM_SETS(NUM_SETS), .STAMP_BITS(STAMP_BITS), .SET_W(SET_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .clearing(clearing),
		.req_data(req_rdata), .req_empty(req_empty), .req_pop(req_pop),
		.out_push(out_push), .out_data(out_wdata), .out_full(out_full)
	);

	swlc_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
		.clk(clk), .arst_n(arst_n), .push(out_push), .wdata(out_wdata), .full(out_full),
		.pop(pop), .rdata(out_rdata), .empty(empty)
	);

	assign hit = out_rdata[ADDR_W+3];
	assign way_used = out_rdata[ADDR_W+2:ADDR_W+1];
	assign write_back = out_rdata[ADDR_W];
	assign evicted_block_address = out_rdata[ADDR_W-1:0];
endmodule

### src/swlc_fifo.sv
// Small queue with push/full and pop/empty sides.
module swlc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### src/swlc_front.sv
// Front end: takes accesses and works out the set index.
module swlc_front #(
	parameter int NUM_SETS = swlc_pkg::DEF_NUM_SETS,
	parameter int SET_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  swlc_pkg::cfg_t            cfg,
	input  logic                      clearing,
	input  logic                      push,
	output logic                      full,
	input  logic                      op,
	input  logic [swlc_pkg::ADDR_W-1:0] address,
	output logic                      req_push,
	output logic [SET_W+swlc_pkg::ADDR_W:0] req_data,
	input  logic                      req_full
);
	import swlc_pkg::*;

	localparam bit SETS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
	localparam int SET_LOG = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 0;
	localparam int DIV_SH = IDX_VAL_W + SET_LOG;
	localparam int MUL_W = IDX_VAL_W + 2;
	localparam longint DIV_MUL =
		((longint'(1) << DIV_SH) + longint'(NUM_SETS) - 1) / longint'(NUM_SETS);

	logic busy_q, op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_VAL_W-1:0] val_q;
	logic [IDX_VAL_W-1:0] quo_q;
	logic [3:0] steps_q;
	logic [ADDR_W-1:0] blk;
	logic [IDX_VAL_W-1:0] idx_val, masked, rem_val;
	logic [IDX_VAL_W+MUL_W-1:0] prod;
	logic [SET_W-1:0] set_out;
	logic accept;

	assign blk = address >> cfg.offset_bits;
	assign idx_val = blk[IDX_VAL_W-1:0] & ~({IDX_VAL_W{1'b1}} << cfg.index_bits);
	assign masked = val_q & IDX_VAL_W'(NUM_SETS - 1);
	// quotient by reciprocal multiplication, exact over the whole index range
	assign prod = (IDX_VAL_W+MUL_W)'(val_q) * (IDX_VAL_W+MUL_W)'(DIV_MUL);
	assign rem_val = val_q - quo_q * IDX_VAL_W'(NUM_SETS);
	assign set_out = SETS_POW2 ? masked[SET_W-1:0] : rem_val[SET_W-1:0];

	assign full = busy_q || clearing;
	assign accept = push && !full;
	assign req_push = busy_q && (steps_q == '0) && !req_full;
	assign req_data = {op_q, addr_q, set_out};

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			addr_q <= address;
			val_q <= idx_val;
		end else if (busy_q && steps_q != '0) begin
			quo_q <= IDX_VAL_W'(prod >> DIV_SH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			steps_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				steps_q <= SETS_POW2 ? 4'd0 : 4'd1;
			end else begin
				if (busy_q && steps_q != '0) begin
					steps_q <= steps_q - 1'b1;
				end
				if (req_push) begin
					busy_q <= 1'b0;
				end
			end
		end
	end
endmodule

### src/swlc_back.sv
// Back end: tag lookup, LRU victim choice and state update.
`include "assert_macros.svh"
module swlc_back #(
	parameter int NUM_WAYS = swlc_pkg::DEF_NUM_WAYS,
	parameter int NUM_SETS = swlc_pkg::DEF_NUM_SETS,
	parameter int STAMP_BITS = swlc_pkg::DEF_STAMP_BITS,
	parameter int SET_W = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  swlc_pkg::cfg_t            cfg,
	output logic                      clearing,
	input  logic [SET_W+swlc_pkg::ADDR_W:0] req_data,
	input  logic                      req_empty,
	output logic                      req_pop,
	output logic                      out_push,
	output logic [swlc_pkg::ADDR_W+3:0] out_data,
	input  logic                      out_full
);
	import swlc_pkg::*;

	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int WCNT_W = $clog2(NUM_WAYS + 1);

	back_state_t state_q, state_d;
	logic [SET_W-1:0] clr_q, set_q;
	logic op_q;
	logic [ADDR_W-1:0] addr_q;
	logic hit_q;
	logic [WAY_W-1:0] chosen_q, scan_q, chosen_d, scan_d;
	logic hit_d, load_look;
	logic [STAMP_BITS-1:0] counter_q;

	logic [ADDR_W-1:0] tag_rd [NUM_WAYS];
	logic [STAMP_BITS-1:0] stamp_rd [NUM_WAYS];
	logic [2*NUM_WAYS-1:0] meta_rd;
	logic [2*NUM_WAYS-1:0] meta_mem [NUM_SETS];

	logic rd_en, wr_en;
	logic [SET_W-1:0] rd_addr;
	logic [2*NUM_WAYS-1:0] meta_wr;
	logic [SET_W-1:0] meta_addr;
	logic meta_we;
	logic [NUM_WAYS-1:0] way_match, way_free;
	logic [WCNT_W-1:0] ways_eff;
	logic [ADDR_W-1:0] block, new_tag, evicted;
	logic wb;

	assign clearing = (state_q == S_CLEAR);
	assign ways_eff = (cfg.ways_in_use == 3'd0) ? WCNT_W'(1)
		: (32'(cfg.ways_in_use) > NUM_WAYS) ? WCNT_W'(NUM_WAYS) : WCNT_W'(cfg.ways_in_use);
	assign block = addr_q >> cfg.offset_bits;
	assign new_tag = addr_q & ({ADDR_W{1'b1}} << cfg.offset_bits);

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			way_match[w] = (WCNT_W'(w) < ways_eff) && meta_rd[2*w]
				&& ((tag_rd[w] >> cfg.offset_bits) == block);
			way_free[w] = (WCNT_W'(w) < ways_eff) && !meta_rd[2*w];
		end
	end

	// memories: one tag and one stamp array per way, one valid/dirty row per set
	for (genvar w = 0; w < NUM_WAYS; w++) begin : g_way
		logic [ADDR_W-1:0] tag_mem [NUM_SETS];
		logic [STAMP_BITS-1:0] stamp_mem [NUM_SETS];
		always_ff @(posedge clk) begin
			if (wr_en && chosen_q == WAY_W'(w)) begin
				stamp_mem[set_q] <= counter_q;
				if (!hit_q) begin
					tag_mem[set_q] <= new_tag;
				end
			end
			if (rd_en) begin
				tag_rd[w] <= tag_mem[rd_addr];
				stamp_rd[w] <= stamp_mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_addr] <= meta_wr;
		end
		if (rd_en) begin
			meta_rd <= meta_mem[rd_addr];
		end
	end

	always_comb begin
		wb = !hit_q && meta_rd[2*chosen_q] && meta_rd[2*chosen_q+1];
		evicted = wb ? tag_rd[chosen_q] : '0;
		meta_wr = meta_rd;
		meta_wr[2*chosen_q] = 1'b1;
		if (hit_q) begin
			meta_wr[2*chosen_q+1] = meta_rd[2*chosen_q+1] | op_q;
		end else begin
			meta_wr[2*chosen_q+1] = op_q;
		end
		if (clearing) begin
			meta_wr = '0;
		end
	end

	assign meta_addr = clearing ? clr_q : set_q;
	assign meta_we = clearing || wr_en;
	assign out_data = {hit_q, 2'(chosen_q), wb, evicted};

	always_comb begin
		state_d = state_q;
		req_pop = 1'b0;
		rd_en = 1'b0;
		rd_addr = req_data[SET_W-1:0];
		wr_en = 1'b0;
		out_push = 1'b0;
		load_look = 1'b0;
		hit_d = 1'b0;
		chosen_d = chosen_q;
		scan_d = scan_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == SET_W'(NUM_SETS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!req_empty) begin
					req_pop = 1'b1;
					rd_en = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				load_look = 1'b1;
				chosen_d = '0;
				scan_d = WAY_W'(1);
				if (|way_match) begin
					hit_d = 1'b1;
					for (int w = NUM_WAYS - 1; w >= 0; w--) begin
						if (way_match[w]) chosen_d = WAY_W'(w);
					end
					state_d = S_WRITE;
				end else if (|way_free) begin
					for (int w = NUM_WAYS - 1; w >= 0; w--) begin
						if (way_free[w]) chosen_d = WAY_W'(w);
					end
					state_d = S_WRITE;
				end else if (ways_eff == WCNT_W'(1)) begin
					state_d = S_WRITE;
				end else begin
					state_d = S_LRU;
				end
			end
			S_LRU: begin
				// one way per cycle against the oldest so far
				if (stamp_rd[scan_q] < stamp_rd[chosen_q]) begin
					chosen_d = scan_q;
				end
				scan_d = scan_q + 1'b1;
				if (WCNT_W'(scan_q) == ways_eff - 1'b1) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				if (!out_full) begin
					wr_en = 1'b1;
					out_push = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			op_q <= req_data[SET_W+ADDR_W];
			addr_q <= req_data[SET_W+ADDR_W-1:SET_W];
			set_q <= req_data[SET_W-1:0];
		end
		if (load_look) begin
			hit_q <= hit_d;
		end
		chosen_q <= chosen_d;
		scan_q <= scan_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			counter_q <= STAMP_BITS'(1);
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_push) begin
				counter_q <= counter_q + 1'b1;
			end
		end
	end

	`SWLC_ASSERT(a_way_in_range, clk, arst_n, (state_q == S_WRITE) |-> (WCNT_W'(chosen_q) < ways_eff), "victim way beyond ways in use")
	`SWLC_ASSERT(a_hit_no_wb, clk, arst_n, (state_q == S_WRITE && hit_q) |-> !wb, "write-back reported on a hit")
	`SWLC_ASSERT(a_pop_to_look, clk, arst_n, req_pop |=> (state_q == S_LOOK), "lookup did not follow queue pop")
	`SWLC_ASSERT_ALWAYS(a_no_out_clear, clk, clearing |-> !out_push, "result during clearing pass")
endmodule

### verif/set_assoc_writeback_cache_lru_core_test.sv
// Self-checking testbench for the set-associative write-back LRU cache tag controller.
`timescale 1ns / 100ps
module set_assoc_writeback_cache_lru_core_test;
	import swlc_pkg::*;

	localparam int WAYS = DEF_NUM_WAYS;
	localparam int SETS = DEF_NUM_SETS;
	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic        hit;
		logic [1:0]  way_used;
		logic        write_back;
		logic [31:0] evicted_block_address;
	} lookup_t;

	typedef struct {
		logic        op;
		logic [31:0] address;
		logic        typed;
		lookup_t     res;
	} access_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic push = 1'b0, full;
	logic op = 1'b0;
	logic [31:0] address = '0;
	logic empty, pop = 1'b0;
	logic hit, write_back;
	logic [1:0] way_used;
	logic [31:0] evicted_block_address;

	set_assoc_writeback_cache_lru_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("set_assoc_writeback_cache_lru_core regression: fail");
		$finish;
	end

	// shadow tag state
	cfg_t        cfg;
	logic [31:0] tag_mem [SETS*WAYS];
	logic        valid_mem [SETS*WAYS];
	logic        dirty_mem [SETS*WAYS];
	logic [31:0] stamp_mem [SETS*WAYS];
	logic [31:0] access_count;

	lookup_t expected_q[$];
	int      errors = 0;
	bit      quiet_tail = 0;
	bit      hold_pop = 0;
	int      hold_cycles = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	function automatic void shadow_reset();
		cfg = '{RST_INDEX_BITS, RST_OFFSET_BITS, RST_WAYS_IN_USE};
		for (int i = 0; i < SETS*WAYS; i++) begin
			valid_mem[i] = 1'b0;
			dirty_mem[i] = 1'b0;
			stamp_mem[i] = '0;
			tag_mem[i] = '0;
		end
		access_count = 32'd1;
	endfunction

	function automatic lookup_t cache_lookup(input logic wr, input logic [31:0] a);
		lookup_t r;
		int ways, set, base, chosen;
		logic [31:0] blk;
		bit found, empty_way;
		r = '0;
		ways = int'(cfg.ways_in_use);
		if (ways == 0) ways = 1;
		if (ways > WAYS) ways = WAYS;
		blk = a >> cfg.offset_bits;
		set = int'((blk & ((32'd1 << cfg.index_bits) - 1)) % SETS);
		base = set * WAYS;
		found = 1'b0;
		chosen = 0;
		for (int w = 0; w < ways; w++)
			if (!found && valid_mem[base+w] && (tag_mem[base+w] >> cfg.offset_bits) == blk) begin
				found = 1'b1;
				chosen = w;
			end
		if (found) begin
			stamp_mem[base+chosen] = access_count;
			if (wr) dirty_mem[base+chosen] = 1'b1;
		end else begin
			empty_way = 1'b0;
			for (int w = 0; w < ways; w++)
				if (!empty_way && !valid_mem[base+w]) begin
					empty_way = 1'b1;
					chosen = w;
				end
			if (!empty_way) begin
				chosen = 0;
				for (int w = 1; w < ways; w++)
					if (stamp_mem[base+w] < stamp_mem[base+chosen]) chosen = w;
			end
			if (valid_mem[base+chosen] && dirty_mem[base+chosen]) begin
				r.write_back = 1'b1;
				r.evicted_block_address = tag_mem[base+chosen];
			end
			tag_mem[base+chosen] = blk << cfg.offset_bits;
			valid_mem[base+chosen] = 1'b1;
			dirty_mem[base+chosen] = wr;
			stamp_mem[base+chosen] = access_count;
		end
		access_count++;
		r.hit = found;
		r.way_used = chosen[1:0];
		return r;
	endfunction

	// result side: random pop bursts, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("unexpected result transfer at %0t", $realtime);
			end else begin
				lookup_t e;
				e = expected_q.pop_front();
				if (hit !== e.hit) report_mismatch("hit", 32'(hit), 32'(e.hit));
				if (way_used !== e.way_used)
					report_mismatch("way_used", 32'(way_used), 32'(e.way_used));
				if (write_back !== e.write_back)
					report_mismatch("write_back", 32'(write_back), 32'(e.write_back));
				if (evicted_block_address !== e.evicted_block_address)
					report_mismatch("evicted_block_address", evicted_block_address,
						e.evicted_block_address);
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			pop <= 1'b0;
		end else if (hold_pop) begin
			hold_cycles <= 400;
			hold_pop <= 0;
			pop <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			hold_cycles <= $urandom_range(0, 2);
			pop <= 1'b0;
		end else
			pop <= 1'b1;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_INDEX_BITS: cfg.index_bits = val[3:0];
			REG_OFFSET_BITS: cfg.offset_bits = val[3:0];
			default: cfg.ways_in_use = val[2:0];
		endcase
	endtask

	task automatic set_geometry(input logic [3:0] ib, input logic [3:0] ob, input logic [2:0] wy);
		wait (expected_q.size() == 0);
		repeat (30) @(posedge clk);
		write_reg(REG_INDEX_BITS, {28'd0, ib});
		write_reg(REG_OFFSET_BITS, {28'd0, ob});
		write_reg(REG_WAYS_IN_USE, {29'd0, wy});
	endtask

	// one access transfer; pushes the prediction when it is accepted
	task automatic send_access(input logic wr, input logic [31:0] a, input bit gaps);
		if (gaps && !quiet_tail && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push <= 1'b1; op <= wr; address <= a;
		do @(posedge clk); while (full);
		expected_q.push_back(cache_lookup(wr, a));
	endtask

	task automatic idle_push();
		push <= 1'b0;
	endtask

	// random address in a small pool of blocks so sets fill and evict
	function automatic logic [31:0] pool_address();
		logic [31:0] a;
		a = $urandom;
		if ($urandom_range(0, 9) != 0) begin
			a[31:14] = {16'd0, 2'($urandom_range(0, 3))} ;
			a[13:6] = 8'($urandom_range(0, 3));
		end
		return a;
	endfunction

	access_row_t directed[$];

	initial begin
		lookup_t e;
		shadow_reset();
		// cold misses, hits and then LRU evictions at reset geometry
		directed = '{
			'{OP_READ, 32'h0000_0000, 1, '{1'b0, 2'd0, 1'b0, 32'd0}},
			'{OP_READ, 32'h0000_000F, 1, '{1'b1, 2'd0, 1'b0, 32'd0}},
			'{OP_WRITE, 32'hFFFF_FFFF, 1, '{1'b0, 2'd0, 1'b0, 32'd0}},
			'{OP_WRITE, 32'h0000_0400, 1, '{1'b0, 2'd1, 1'b0, 32'd0}},
			'{OP_READ, 32'h0000_0800, 1, '{1'b0, 2'd2, 1'b0, 32'd0}},
			'{OP_READ, 32'h0000_0C00, 1, '{1'b0, 2'd3, 1'b0, 32'd0}},
			'{OP_WRITE, 32'h0000_0000, 0, '0},
			'{OP_READ, 32'h0000_1000, 0, '0},
			'{OP_READ, 32'h0000_1400, 0, '0},
			'{OP_WRITE, 32'h0000_0404, 0, '0},
			'{OP_READ, 32'h0000_1800, 0, '0},
			'{OP_READ, 32'h0000_0000, 0, '0},
			'{OP_READ, 32'hFFFF_FFF0, 0, '0},
			'{OP_WRITE, 32'h8000_0000, 0, '0}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) begin
			send_access(directed[i].op, directed[i].address, 0);
			if (directed[i].typed) begin
				e = expected_q.pop_back();
				expected_q.push_back(directed[i].res);
			end
		end
		idle_push();
		// extreme geometries: wide index/offset, one way, ways 0 and beyond range
		set_geometry(4'd15, 4'd15, 3'd0);
		for (int i = 0; i < 10; i++) send_access(i[0], {i[1:0], 30'h0} ^ 32'h0000_8000, 0);
		idle_push();
		set_geometry(4'd0, 4'd0, 3'd7);
		for (int i = 0; i < 10; i++) send_access(i[0], 32'(i % 6), 0);
		idle_push();
		// random phases across geometries
		for (int ph = 0; ph < 6; ph++) begin
			set_geometry(4'($urandom_range(0, 9)), 4'($urandom_range(0, 13)),
				3'($urandom_range(0, 7)));
			if (ph == 5) set_geometry(4'd8, 4'd12, 3'd4);
			if (ph == 2) hold_pop = 1;
			if (ph == 5) quiet_tail = 1;
			for (int i = 0; i < 210; i++)
				send_access(1'($urandom_range(0, 1)), pool_address(), 1);
			idle_push();
		end
		fork
			wait (expected_q.size() == 0);
			begin
				repeat (200000) @(posedge clk);
				errors++;
			end
		join_any
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("set_assoc_writeback_cache_lru_core regression: pass");
		else
			$display("set_assoc_writeback_cache_lru_core regression: fail");
		$finish;
	end
endmodule
